[hdl/wpas_pkg.sv]
// Shared types and constants of the three-band peak level meter.
// No dependencies; every other file in this folder imports it.
package wpas_pkg;

  localparam int BANDS          = 3;
  localparam int BAND_BASS      = 0;
  localparam int BAND_MID       = 1;
  localparam int BAND_TREBLE    = 2;

  localparam int SAMPLE_W       = 10;
  localparam int SCALED_W       = 8;
  localparam int AMP_W          = 7;
  localparam int LEVEL_W        = 7;
  localparam int WEIGHT_W       = 9;
  localparam int FULL_SCALE_W   = 8;
  localparam int MAX_HEIGHT_W   = 7;

  // Reading scale: floor(x * SCALE_MUL / SCALE_DIV), SCALE_DIV = 2**SCALE_SHIFT - 1
  localparam int SCALE_MUL      = 225;
  localparam int SCALE_DIV      = 1023;
  localparam int SCALE_SHIFT    = 10;
  localparam int SCALE_PROD_W   = SAMPLE_W + 8;

  localparam int AMP_MAX        = SCALE_MUL / 2;

  // Height division: dividend amp * max_height
  localparam int PROD_W         = AMP_W + MAX_HEIGHT_W;

  // Smoothing weight in Q1.8
  localparam int WEIGHT_FRAC    = 8;
  localparam int WEIGHT_ONE     = 256;
  localparam int MIX_W          = WEIGHT_W + LEVEL_W;

  localparam int WINDOW_LENGTH_DEF = 50;

  localparam int REG_IDX_W      = 2;
  localparam int CFG_DATA_W     = WEIGHT_W;

  localparam logic [WEIGHT_W-1:0]     WEIGHT_RST     = 9'd51;
  localparam logic [FULL_SCALE_W-1:0] FULL_SCALE_RST = 8'd125;
  localparam logic [MAX_HEIGHT_W-1:0] MAX_HEIGHT_RST = 7'd60;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WEIGHT     = 2'd0,
    REG_FULL_SCALE = 2'd1,
    REG_MAX_HEIGHT = 2'd2
  } reg_idx_e;

  typedef logic [SCALED_W-1:0]             scaled_t;
  typedef logic [BANDS-1:0][SCALED_W-1:0]  entry_t;

endpackage

[hdl/wpas_if.sv]
// Channel interfaces of the level meter: sample input, result output, register writes.
// Depends on wpas_pkg.
interface wpas_sample_if;
  import wpas_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] bass_sample;
  logic [SAMPLE_W-1:0] mid_sample;
  logic [SAMPLE_W-1:0] treble_sample;
  modport source (output valid, bass_sample, mid_sample, treble_sample, input ready);
  modport sink   (input valid, bass_sample, mid_sample, treble_sample, output ready);
endinterface

interface wpas_result_if;
  import wpas_pkg::*;
  logic               valid;
  logic               ready;
  logic [AMP_W-1:0]   bass_amplitude;
  logic [AMP_W-1:0]   mid_amplitude;
  logic [AMP_W-1:0]   treble_amplitude;
  logic [LEVEL_W-1:0] bass_level;
  logic [LEVEL_W-1:0] mid_level;
  logic [LEVEL_W-1:0] treble_level;
  modport source (output valid, bass_amplitude, mid_amplitude, treble_amplitude,
                  bass_level, mid_level, treble_level, input ready);
  modport sink   (input valid, bass_amplitude, mid_amplitude, treble_amplitude,
                  bass_level, mid_level, treble_level, output ready);
endinterface

interface wpas_cfg_if;
  import wpas_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[hdl/wpas_cell.sv]
// One window cell: holds the three scaled band values of one entry.
// Depends on wpas_pkg.
module wpas_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  wpas_pkg::entry_t data_i,
  output wpas_pkg::entry_t data_o
);
  import wpas_pkg::*;

  entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

[hdl/wpas_div.sv]
// Restoring divider, one quotient bit per cycle, for the bar height.
// Depends on wpas_pkg.
module wpas_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [wpas_pkg::PROD_W-1:0]       dividend_i,
  input  logic [wpas_pkg::FULL_SCALE_W-1:0] divisor_i,
  output logic [wpas_pkg::PROD_W-1:0]       quotient_o,
  output logic                              last_o
);
  import wpas_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0]       num_q, num_d;
  logic [FULL_SCALE_W-1:0] rem_q, rem_d;
  logic [FULL_SCALE_W-1:0] dvs_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [FULL_SCALE_W:0]   rem_sh;
  logic                    qbit;

  // Shift the next dividend bit into the remainder; subtract when it fits.
  always_comb begin
    rem_sh = {rem_q, num_q[PROD_W-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    rem_d  = qbit ? FULL_SCALE_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[FULL_SCALE_W-1:0];
    num_d  = {num_q[PROD_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(PROD_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = num_q;
  assign last_o     = (cnt_q == CNT_W'(1));

endmodule

[hdl/windowed_peak_amplitude_smoother.sv]
// Three-band peak-to-peak level meter with exponential smoothing (top level).
// Accepts a new sample set only when idle, after the previous result is loaded into the
//   output register; the pace is set by the rotation scan of the cell chain (one entry
//   per cycle) and the 14-step height divider.
// Reset: async active low; window cells, levels and control clear, registers take defaults.
// Depends on wpas_pkg, wpas_if, wpas_cell, wpas_div.
module windowed_peak_amplitude_smoother #(
  parameter int WINDOW_LENGTH = wpas_pkg::WINDOW_LENGTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  wpas_sample_if.sink  sample_i,
  wpas_result_if.source result_o,
  wpas_cfg_if.sink     cfg_i
);
  import wpas_pkg::*;

  localparam int SCAN_W = $clog2(WINDOW_LENGTH);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_LOAD   = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_HMUL   = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_SMOOTH = 7'b1000000
  } state_e;

  // Reading scale: divide by 1023 through a reciprocal estimate plus one correction.
  function automatic scaled_t scale_reading(input logic [SCALE_PROD_W-1:0] p);
    logic [SCALE_PROD_W-1:0] sum;
    logic [SCALE_PROD_W:0]   rem;
    scaled_t                 q;
    sum = p + (p >> SCALE_SHIFT);
    q   = SCALED_W'(sum >> SCALE_SHIFT);
    rem = {1'b0, p} + (SCALE_PROD_W + 1)'(q) - ((SCALE_PROD_W + 1)'(q) << SCALE_SHIFT);
    if (rem >= (SCALE_PROD_W + 1)'(SCALE_DIV)) begin
      q = q + SCALED_W'(1);
    end
    return q;
  endfunction

  state_e state_q, state_d;

  // ---------------------------------------------------------------------------
  // Configuration registers; always ready, unknown indices drop the write.
  // ---------------------------------------------------------------------------
  logic [WEIGHT_W-1:0]     weight_q;
  logic [FULL_SCALE_W-1:0] full_scale_q;
  logic [MAX_HEIGHT_W-1:0] max_height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q     <= WEIGHT_RST;
      full_scale_q <= FULL_SCALE_RST;
      max_height_q <= MAX_HEIGHT_RST;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.reg_index))
        REG_WEIGHT:     weight_q     <= cfg_i.wdata;
        REG_FULL_SCALE: full_scale_q <= cfg_i.wdata[FULL_SCALE_W-1:0];
        REG_MAX_HEIGHT: max_height_q <= cfg_i.wdata[MAX_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings: weight saturates at one, zero full scale acts as one.
  logic [WEIGHT_W-1:0]     w_eff, w_inv;
  logic [FULL_SCALE_W-1:0] fs_eff;

  assign w_eff  = (weight_q > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : weight_q;
  assign w_inv  = WEIGHT_W'(WEIGHT_ONE) - w_eff;
  assign fs_eff = (full_scale_q == '0) ? FULL_SCALE_W'(1) : full_scale_q;

  // ---------------------------------------------------------------------------
  // Input capture and reading scale.
  // ---------------------------------------------------------------------------
  logic                                       in_xfer;
  logic [BANDS-1:0][SAMPLE_W-1:0]             raw_q;
  logic [BANDS-1:0][SCALE_PROD_W-1:0]         prod_q;
  entry_t                                     scaled;

  assign sample_i.ready = (state_q == S_IDLE);
  assign in_xfer        = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      raw_q[BAND_BASS]   <= sample_i.bass_sample;
      raw_q[BAND_MID]    <= sample_i.mid_sample;
      raw_q[BAND_TREBLE] <= sample_i.treble_sample;
    end
    if (state_q == S_MUL) begin
      for (int b = 0; b < BANDS; b++) begin
        prod_q[b] <= SCALE_PROD_W'(raw_q[b]) * SCALE_PROD_W'(SCALE_MUL);
      end
    end
  end

  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      scaled[b] = scale_reading(prod_q[b]);
    end
  end

  // ---------------------------------------------------------------------------
  // Window: a chain of cells. LOAD shifts the new entry in and drops the oldest;
  // SCAN rotates the chain once around, so every entry passes the tail for the
  // min/max tracker and the chain ends in its original order.
  // ---------------------------------------------------------------------------
  logic   chain_shift;
  entry_t chain_head;
  entry_t cell_out [WINDOW_LENGTH];
  entry_t tail;

  assign chain_shift = (state_q == S_LOAD) || (state_q == S_SCAN);
  assign tail        = cell_out[WINDOW_LENGTH-1];
  assign chain_head  = (state_q == S_LOAD) ? scaled : tail;

  for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
    entry_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = chain_head;
    end else begin : g_link
      assign cell_in = cell_out[i-1];
    end
    wpas_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(chain_shift),
      .data_i (cell_in),
      .data_o (cell_out[i])
    );
  end

  logic [SCAN_W-1:0] scan_cnt_q;
  entry_t            max_q, min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
    end else if (state_q == S_LOAD) begin
      scan_cnt_q <= '0;
    end else if (state_q == S_SCAN) begin
      scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      max_q <= '0;
      min_q <= '1;
    end else if (state_q == S_SCAN) begin
      for (int b = 0; b < BANDS; b++) begin
        if (tail[b] > max_q[b]) max_q[b] <= tail[b];
        if (tail[b] < min_q[b]) min_q[b] <= tail[b];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Amplitude and height: amp * max_height goes straight into the dividers.
  // ---------------------------------------------------------------------------
  logic [BANDS-1:0][AMP_W-1:0]  amp_d, amp_q;
  logic [BANDS-1:0][PROD_W-1:0] div_num, quot;
  logic [BANDS-1:0]             div_last;

  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      amp_d[b]   = AMP_W'((max_q[b] - min_q[b]) >> 1);
      div_num[b] = PROD_W'(amp_d[b]) * PROD_W'(max_height_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_HMUL) begin
      amp_q <= amp_d;
    end
  end

  for (genvar b = 0; b < BANDS; b++) begin : g_div
    wpas_div u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (state_q == S_HMUL),
      .dividend_i(div_num[b]),
      .divisor_i (fs_eff),
      .quotient_o(quot[b]),
      .last_o    (div_last[b])
    );
  end

  // ---------------------------------------------------------------------------
  // Clamp and smooth; hold in SMOOTH until the output register is free.
  // ---------------------------------------------------------------------------
  logic [BANDS-1:0][LEVEL_W-1:0] lev_q, lev_d;
  logic [BANDS-1:0][LEVEL_W-1:0] height;
  logic [BANDS-1:0][MIX_W-1:0]   mix;
  logic                          out_valid_q;
  logic                          out_load;
  logic [BANDS-1:0][AMP_W-1:0]   out_amp_q;
  logic [BANDS-1:0][LEVEL_W-1:0] out_lev_q;

  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      height[b] = (quot[b] > PROD_W'(max_height_q)) ? max_height_q
                                                     : quot[b][LEVEL_W-1:0];
      mix[b]    = MIX_W'(w_eff) * MIX_W'(height[b]) + MIX_W'(w_inv) * MIX_W'(lev_q[b]);
      lev_d[b]  = LEVEL_W'(mix[b] >> WEIGHT_FRAC);
    end
  end

  assign out_load = (state_q == S_SMOOTH) && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lev_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      lev_q       <= lev_d;
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_amp_q <= amp_q;
      out_lev_q <= lev_d;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.bass_amplitude   = out_amp_q[BAND_BASS];
  assign result_o.mid_amplitude    = out_amp_q[BAND_MID];
  assign result_o.treble_amplitude = out_amp_q[BAND_TREBLE];
  assign result_o.bass_level       = out_lev_q[BAND_BASS];
  assign result_o.mid_level        = out_lev_q[BAND_MID];
  assign result_o.treble_level     = out_lev_q[BAND_TREBLE];

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_MUL;
      S_MUL:    state_d = S_LOAD;
      S_LOAD:   state_d = S_SCAN;
      S_SCAN:   if (scan_cnt_q == SCAN_W'(WINDOW_LENGTH - 1)) state_d = S_HMUL;
      S_HMUL:   state_d = S_DIV;
      S_DIV:    if (&div_last) state_d = S_SMOOTH;
      S_SMOOTH: if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_result_from_smooth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_SMOOTH))
    else $error("result valid rose outside the smoothing step");

  a_scan_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan_cnt_q == SCAN_W'(WINDOW_LENGTH - 1)) |=> state_q == S_HMUL)
    else $error("window scan did not end after one full rotation");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_last == '0 || div_last == '1))
    else $error("band dividers out of step");

  a_amp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_amp_q[BAND_BASS] <= AMP_W'(AMP_MAX) &&
                     out_amp_q[BAND_MID] <= AMP_W'(AMP_MAX) &&
                     out_amp_q[BAND_TREBLE] <= AMP_W'(AMP_MAX)))
    else $error("amplitude above half the scaled range");

endmodule

[tb/tb_windowed_peak_amplitude_smoother.sv]
// Self-checking testbench of the three-band peak level meter with smoothing.
// Drives sample and result channels with random idling, writes registers;
// checks every result against an internal predictor. Depends on wpas_pkg, wpas_if.
module tb_windowed_peak_amplitude_smoother;
  timeunit 1ns;
  timeprecision 1ps;

  import wpas_pkg::*;

  localparam int WIN             = WINDOW_LENGTH_DEF;
  // Settling pause after the last checked result, used before register writes
  // and at the end of the run.
  localparam int LATENCY         = WIN + 18;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int TIMEOUT_NS      = 5_000_000;

  // No register lives at this index: writes to it must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic [BANDS-1:0][SAMPLE_W-1:0] sample_set_t;

  typedef struct packed {
    logic [BANDS-1:0][AMP_W-1:0]   amp;
    logic [BANDS-1:0][LEVEL_W-1:0] level;
  } meter_result_t;

  logic clk_i;
  logic rst_ni;

  wpas_sample_if smp ();
  wpas_result_if res ();
  wpas_cfg_if    cfg ();

  windowed_peak_amplitude_smoother dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp),
    .result_o (res),
    .cfg_i    (cfg)
  );

  // Predictor state: register copies, scaled windows, ring position, levels.
  logic [WEIGHT_W-1:0]     weight_q;
  logic [FULL_SCALE_W-1:0] full_scale_q;
  logic [MAX_HEIGHT_W-1:0] max_height_q;
  logic [SCALED_W-1:0]     window_q [BANDS][WIN];
  int unsigned             wr_pos;
  logic [LEVEL_W-1:0]      level_q [BANDS];

  sample_set_t   pending_samples [$];
  meter_result_t expected_results [$];
  sample_set_t   driven_item;
  int            error_count;
  int            send_idle_pct;
  int            recv_stall_pct;

  string band_name [BANDS] = '{"bass", "mid", "treble"};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Mirror a register write into the predictor; unknown indexes drop out.
  function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WEIGHT:     weight_q     = data[WEIGHT_W-1:0];
      REG_FULL_SCALE: full_scale_q = data[FULL_SCALE_W-1:0];
      REG_MAX_HEIGHT: max_height_q = data[MAX_HEIGHT_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the meter by one sample set and return the amplitudes and levels it reports.
  function automatic meter_result_t meter_step(input sample_set_t s);
    meter_result_t r;
    int unsigned   w, fs, hi, lo, amp, height, mixed;
    // Clamp the weight to one and treat a zero full scale as one.
    w  = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
    fs = (full_scale_q == 0) ? 1 : full_scale_q;
    for (int b = 0; b < BANDS; b++)
      window_q[b][wr_pos] = SCALED_W'((int'(s[b]) * SCALE_MUL) / SCALE_DIV);
    wr_pos = (wr_pos + 1) % WIN;
    for (int b = 0; b < BANDS; b++) begin
      // Unwritten entries still hold zero and count in the scan.
      hi = 0;
      lo = 255;
      for (int i = 0; i < WIN; i++) begin
        if (window_q[b][i] > hi) hi = 32'(window_q[b][i]);
        if (window_q[b][i] < lo) lo = 32'(window_q[b][i]);
      end
      amp    = (hi - lo) / 2;
      height = (amp * max_height_q) / fs;
      if (height > max_height_q) height = 32'(max_height_q);
      mixed      = (w * height + (WEIGHT_ONE - w) * level_q[b]) >> WEIGHT_FRAC;
      level_q[b] = LEVEL_W'(mixed);
      r.amp[b]   = AMP_W'(amp);
      r.level[b] = level_q[b];
    end
    return r;
  endfunction

  // Sample driver: hold valid until the transfer, then either present the
  // next pending set or idle at the configured rate.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp.valid <= 1'b0;
    end else begin
      if (smp.valid && smp.ready)
        expected_results.push_back(meter_step(driven_item));
      if (!smp.valid || smp.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_item       = pending_samples.pop_front();
          smp.valid         <= 1'b1;
          smp.bass_sample   <= driven_item[BAND_BASS];
          smp.mid_sample    <= driven_item[BAND_MID];
          smp.treble_sample <= driven_item[BAND_TREBLE];
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation and
  // stall ready at random.
  always @(posedge clk_i) begin
    meter_result_t got, want;
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got.amp[BAND_BASS]     = res.bass_amplitude;
        got.amp[BAND_MID]      = res.mid_amplitude;
        got.amp[BAND_TREBLE]   = res.treble_amplitude;
        got.level[BAND_BASS]   = res.bass_level;
        got.level[BAND_MID]    = res.mid_level;
        got.level[BAND_TREBLE] = res.treble_level;
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result pending");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          for (int b = 0; b < BANDS; b++) begin
            if (got.amp[b] !== want.amp[b]) begin
              $error("%s_amplitude: expected %0d, got %0d",
                     band_name[b], want.amp[b], got.amp[b]);
              error_count++;
            end
            if (got.level[b] !== want.level[b]) begin
              $error("%s_level: expected %0d, got %0d",
                     band_name[b], want.level[b], got.level[b]);
              error_count++;
            end
          end
        end
      end
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write one register through the configuration channel; block is idle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata     <= data;
    do @(posedge clk_i); while (!cfg.ready);
    apply_reg(idx, data);
    cfg.valid <= 1'b0;
  endtask

  // Queue a burst of sample sets around a per-band base. Narrow bursts
  // longer than the window give small amplitudes and a nonzero minimum;
  // the noise case spreads over the full reading range.
  task automatic queue_burst(input int count);
    int          base [BANDS];
    int          spread, v;
    sample_set_t s;
    case ($urandom_range(3))
      0:       spread = 0;
      1:       spread = 6;
      2:       spread = 60;
      default: spread = -1;
    endcase
    for (int b = 0; b < BANDS; b++) base[b] = $urandom_range(1023);
    repeat (count) begin
      for (int b = 0; b < BANDS; b++) begin
        if (spread < 0) v = $urandom_range(1023);
        else v = base[b] + int'($urandom_range(spread)) - spread / 2;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        s[b] = SAMPLE_W'(v);
      end
      pending_samples.push_back(s);
    end
  endtask

  // Wait until every set is transferred and every result checked, then
  // let the pipeline settle. Sample at the falling edge to avoid races
  // with the driver.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || smp.valid || expected_results.size() != 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  initial begin
    int                      p, queued, n;
    logic [CFG_DATA_W-1:0]   wt, fs, mh;
    sample_set_t             directed [$];

    // Known values on every input from time zero.
    rst_ni            = 1'b0;
    smp.valid         = 1'b0;
    smp.bass_sample   = '0;
    smp.mid_sample    = '0;
    smp.treble_sample = '0;
    res.ready         = 1'b0;
    cfg.valid         = 1'b0;
    cfg.reg_index     = '0;
    cfg.wdata         = '0;
    error_count       = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;

    weight_q     = WEIGHT_RST;
    full_scale_q = FULL_SCALE_RST;
    max_height_q = MAX_HEIGHT_RST;
    wr_pos       = 0;
    for (int b = 0; b < BANDS; b++) begin
      level_q[b] = '0;
      for (int i = 0; i < WIN; i++) window_q[b][i] = '0;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed sets under reset register values: reading extremes, bit
    // patterns and mixes, while the window still holds cleared entries.
    directed = '{
      {10'd0,    10'd0,    10'd0},
      {10'd1023, 10'd1023, 10'd1023},
      {10'd511,  10'd0,    10'd1023},
      {10'h3FF,  10'h155,  10'h2AA},
      {10'h000,  10'h2AA,  10'h155},
      {10'd512,  10'd1022, 10'd1},
      {10'd0,    10'd1023, 10'd0},
      {10'd512,  10'd512,  10'd512},
      {10'd1018, 10'd5,    10'd1000},
      {10'd5,    10'd4,    10'd3},
      {10'd1023, 10'd0,    10'd1023},
      {10'd1023, 10'd1023, 10'd1023},
      {10'd0,    10'd0,    10'd0},
      {10'd5,    10'd1019, 10'd4}
    };
    foreach (directed[i]) pending_samples.push_back(directed[i]);
    drain();

    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase

      // Walk the registers through defaults, extremes and out-of-range
      // values; upper write bits beyond a register's width drop out.
      case (p)
        0: begin wt = 9'd51;  fs = 9'd125; mh = 9'd60;  end
        1: begin wt = 9'd0;   fs = 9'd1;   mh = 9'd1;   end
        2: begin wt = 9'd256; fs = 9'd255; mh = 9'd64;  end
        3: begin wt = 9'd511; fs = 9'd256; mh = 9'd511; end
        4: begin wt = 9'd128; fs = 9'd200; mh = 9'd0;   end
        5: begin wt = 9'd257; fs = 9'd17;  mh = 9'd100; end
        default: begin
          wt = CFG_DATA_W'($urandom_range(511));
          fs = CFG_DATA_W'($urandom_range(511));
          mh = CFG_DATA_W'($urandom_range(511));
        end
      endcase
      write_reg(REG_WEIGHT, wt);
      write_reg(REG_FULL_SCALE, fs);
      write_reg(REG_MAX_HEIGHT, mh);
      if (p % 2 == 1) write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(511)));

      queued = 0;
      while (queued < ITEMS_PER_PHASE) begin
        n = $urandom_range(10, 70);
        if (n > ITEMS_PER_PHASE - queued) n = ITEMS_PER_PHASE - queued;
        queue_burst(n);
        queued += n;
      end
      drain();
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
